// ----- rtl/core/pnl_pkg.sv -----
package pnl_pkg;

	localparam int MAX_NEIGHBORS = 1024;
	localparam int SLOT_W        = $clog2(MAX_NEIGHBORS);
	localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);

	localparam int POS_W    = 32;
	localparam int BOX_W    = 31;
	localparam int CUT_W    = 63;
	localparam int WORD_W   = 32;
	localparam int CFG_DW   = 63;
	localparam int CFG_AW   = 2;
	localparam int IMG_W    = POS_W + 2;
	localparam int DL_W     = IMG_W + 1;
	localparam int SQ_W     = 2 * POS_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int NAXES    = 3;

	localparam int WRAP_STEPS = POS_W;
	localparam int STEP_W     = $clog2(WRAP_STEPS);

	typedef enum logic [CFG_AW-1:0] {
		CFG_BOX_X  = 2'd0,
		CFG_BOX_Y  = 2'd1,
		CFG_BOX_Z  = 2'd2,
		CFG_CUTOFF = 2'd3
	} cfg_addr_t;

	typedef enum logic [1:0] {
		RK_CENTER   = 2'd0,
		RK_NEIGHBOR = 2'd1,
		RK_DROPPED  = 2'd2
	} rkind_t;

	typedef enum logic [1:0] {
		SH_NEG  = 2'd0,
		SH_ZERO = 2'd1,
		SH_POS  = 2'd2
	} shift_t;

	typedef enum logic {
		KIND_CENTER = 1'b0,
		KIND_ATOM   = 1'b1
	} in_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic   capture;
		logic   wrap_step;
		logic   emit_center;
		logic   issue;
		shift_t sx;
		shift_t sy;
		shift_t sz;
		logic   final_img;
	} pnl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic en;
		logic busy;
	} pnl_stat_t;

endpackage

// ----- rtl/core/pnl_wrap.sv -----
module pnl_wrap (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic signed [pnl_pkg::POS_W-1:0]  load_pos,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos,
	input  logic        [pnl_pkg::BOX_W-1:0]  box,
	output logic signed [pnl_pkg::POS_W-1:0]  wrapped
);
	import pnl_pkg::*;

	// restoring remainder of |pos| by box, one dividend bit per cycle
	logic [POS_W-1:0] dvd_q;
	logic [BOX_W-1:0] rem_q;
	logic [POS_W-1:0] trial;
	logic [POS_W-1:0] box_ext;
	logic [POS_W-1:0] diff;
	logic [BOX_W-1:0] fix;

	assign box_ext = {1'b0, box};
	assign trial   = {rem_q, dvd_q[POS_W-1]};
	assign diff    = trial - box_ext;
	assign fix     = box - rem_q;

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= load_pos[POS_W-1] ? (~load_pos + 1'b1) : load_pos;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
			rem_q <= (trial >= box_ext) ? diff[BOX_W-1:0] : trial[BOX_W-1:0];
		end
	end

	// negative input with nonzero remainder folds up into [0, box)
	always_comb begin
		if (box == '0) begin
			wrapped = pos;
		end else if (pos[POS_W-1] && (rem_q != '0)) begin
			wrapped = {1'b0, fix};
		end else begin
			wrapped = {1'b0, rem_q};
		end
	end

endmodule

// ----- rtl/core/pnl_ctrl.sv -----
module pnl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output pnl_pkg::pnl_cmd_t  cmd,
	input  pnl_pkg::pnl_stat_t stat
);
	import pnl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_EMIT,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	shift_t            sx_q, sy_q, sz_q;
	logic              last_img;

	function automatic shift_t sh_next(input shift_t s);
		case (s)
			SH_NEG:  sh_next = SH_ZERO;
			SH_ZERO: sh_next = SH_POS;
			default: sh_next = SH_NEG;
		endcase
	endfunction

	assign last_img = (sx_q == SH_POS) && (sy_q == SH_POS) && (sz_q == SH_POS);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == S_IDLE) && in_valid;
		cmd.wrap_step   = (state_q == S_WRAP);
		cmd.emit_center = (state_q == S_EMIT);
		cmd.issue       = (state_q == S_SCAN);
		cmd.sx          = sx_q;
		cmd.sy          = sy_q;
		cmd.sz          = sz_q;
		cmd.final_img   = last_img;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			sx_q    <= SH_NEG;
			sy_q    <= SH_NEG;
			sz_q    <= SH_NEG;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					sx_q   <= SH_NEG;
					sy_q   <= SH_NEG;
					sz_q   <= SH_NEG;
					if (in_valid) begin
						state_q <= (in_kind == KIND_CENTER) ? S_WRAP : S_SCAN;
					end
				end
				S_WRAP: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(WRAP_STEPS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.en) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (stat.en) begin
						sz_q <= sh_next(sz_q);
						if (sz_q == SH_POS) begin
							sy_q <= sh_next(sy_q);
							if (sy_q == SH_POS) begin
								sx_q <= sh_next(sx_q);
							end
						end
						if (last_img) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (!stat.busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/pnl_dp.sv -----
module pnl_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pnl_pkg::pnl_cmd_t                 cmd,
	output pnl_pkg::pnl_stat_t                stat,
	input  logic                              cfg_en,
	input  logic [pnl_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [pnl_pkg::CFG_DW-1:0]        cfg_data,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_x,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_y,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_z,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_a,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_b,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_c,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_a,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_b,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_c,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        result_kind,
	output logic signed [pnl_pkg::POS_W-1:0]  out_x,
	output logic signed [pnl_pkg::POS_W-1:0]  out_y,
	output logic signed [pnl_pkg::POS_W-1:0]  out_z,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_a,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_b,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_c,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_a,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_b,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_c,
	output logic [pnl_pkg::SLOT_W-1:0]        slot,
	output logic                              last
);
	import pnl_pkg::*;

	typedef enum logic [1:0] {
		OS_CENTER,
		OS_PEND,
		OS_CUR
	} osel_t;

	// configuration
	logic [BOX_W-1:0] box_q [NAXES];
	logic [CUT_W-1:0] cut_q;

	// captured item
	logic [POS_W-1:0]  pos_q  [NAXES];
	logic [WORD_W-1:0] pair_q [6];

	// list state
	logic [POS_W-1:0] center_q [NAXES];
	logic [CNT_W-1:0] cnt_q;

	// wrap units
	logic [POS_W-1:0] in_pos  [NAXES];
	logic [POS_W-1:0] wrapped [NAXES];

	// image pipeline
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic             fin_s1, fin_s2, fin_s3, fin_s4, fin_s5, fin_s6;
	logic [IMG_W-1:0] img_s1 [NAXES];
	logic [IMG_W-1:0] img_s2 [NAXES];
	logic [IMG_W-1:0] img_s3 [NAXES];
	logic [IMG_W-1:0] img_s4 [NAXES];
	logic [IMG_W-1:0] img_s5 [NAXES];
	logic [IMG_W-1:0] img_s6 [NAXES];
	logic [DL_W-1:0]  dl_s2  [NAXES];
	logic [POS_W-1:0] mag_s3 [NAXES];
	logic             big_s3 [NAXES];
	logic [SQ_W-1:0]  sq_s4  [NAXES];
	logic             big_s4;
	logic [SUM_W-1:0] sum_s5;
	logic             big_s5;
	logic             hit_s6;

	logic [IMG_W-1:0] img_d  [NAXES];
	logic [DL_W-1:0]  dl_d   [NAXES];
	logic [DL_W-1:0]  mag_d  [NAXES];
	shift_t           sh     [NAXES];

	// pending hit: held until we know whether it is the final one
	logic             pend_v_q;
	logic             flush_q;
	logic [POS_W-1:0] pend_c_q [NAXES];
	rkind_t           pend_kind_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic [POS_W-1:0] cur_c  [NAXES];
	rkind_t           cur_kind;
	logic [SLOT_W-1:0] cur_slot;
	logic             cur_hit;
	logic             room;

	// output register
	logic             out_valid_q;
	rkind_t           out_kind_q;
	logic [POS_W-1:0] out_c_q  [NAXES];
	logic [WORD_W-1:0] out_pair_q [6];
	logic [SLOT_W-1:0] out_slot_q;
	logic             out_last_q;

	logic             en;
	logic             ld_out;
	osel_t            ld_sel;
	logic             ld_last;
	logic             pend_set;
	logic             pend_clr;
	logic             flush_set;

	function automatic logic [POS_W-1:0] sat_img(input logic [IMG_W-1:0] v);
		if (!v[IMG_W-1] && (v[IMG_W-2:POS_W-1] != '0)) begin
			sat_img = {1'b0, {(POS_W-1){1'b1}}};
		end else if (v[IMG_W-1] && (v[IMG_W-2:POS_W-1] != '1)) begin
			sat_img = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			sat_img = v[POS_W-1:0];
		end
	endfunction

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;

	for (genvar a = 0; a < NAXES; a++) begin : g_wrap
		pnl_wrap u_wrap (
			.clk      (clk),
			.load     (cmd.capture),
			.step     (cmd.wrap_step),
			.load_pos (in_pos[a]),
			.pos      (pos_q[a]),
			.box      (box_q[a]),
			.wrapped  (wrapped[a])
		);
	end

	// whole pipe moves only when the output register can take an item
	assign en        = !out_valid_q || out_ready;
	assign stat.en   = en;
	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | pend_v_q | flush_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0] <= BOX_W'(65536);
			box_q[1] <= BOX_W'(65536);
			box_q[2] <= BOX_W'(65536);
			cut_q    <= '0;
		end else if (cfg_en) begin
			case (cfg_addr_t'(cfg_addr))
				CFG_BOX_X:  box_q[0] <= cfg_data[BOX_W-1:0];
				CFG_BOX_Y:  box_q[1] <= cfg_data[BOX_W-1:0];
				CFG_BOX_Z:  box_q[2] <= cfg_data[BOX_W-1:0];
				CFG_CUTOFF: cut_q    <= cfg_data[CUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int a = 0; a < NAXES; a++) pos_q[a] <= in_pos[a];
			pair_q[0] <= radius_a;
			pair_q[1] <= radius_b;
			pair_q[2] <= radius_c;
			pair_q[3] <= energy_a;
			pair_q[4] <= energy_b;
			pair_q[5] <= energy_c;
		end
	end

	// image stages
	assign sh[0] = cmd.sx;
	assign sh[1] = cmd.sy;
	assign sh[2] = cmd.sz;

	always_comb begin
		for (int a = 0; a < NAXES; a++) begin
			case (sh[a])
				SH_NEG:  img_d[a] = {{(IMG_W-POS_W){pos_q[a][POS_W-1]}}, pos_q[a]}
				                  - {{(IMG_W-BOX_W){1'b0}}, box_q[a]};
				SH_POS:  img_d[a] = {{(IMG_W-POS_W){pos_q[a][POS_W-1]}}, pos_q[a]}
				                  + {{(IMG_W-BOX_W){1'b0}}, box_q[a]};
				default: img_d[a] = {{(IMG_W-POS_W){pos_q[a][POS_W-1]}}, pos_q[a]};
			endcase
			dl_d[a]  = {img_s1[a][IMG_W-1], img_s1[a]}
			         - {{(DL_W-POS_W){center_q[a][POS_W-1]}}, center_q[a]};
			mag_d[a] = dl_s2[a][DL_W-1] ? (~dl_s2[a] + 1'b1) : dl_s2[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s1 <= cmd.final_img;
			fin_s2 <= fin_s1;
			fin_s3 <= fin_s2;
			fin_s4 <= fin_s3;
			fin_s5 <= fin_s4;
			fin_s6 <= fin_s5;
			for (int a = 0; a < NAXES; a++) begin
				img_s1[a] <= img_d[a];
				img_s2[a] <= img_s1[a];
				img_s3[a] <= img_s2[a];
				img_s4[a] <= img_s3[a];
				img_s5[a] <= img_s4[a];
				img_s6[a] <= img_s5[a];
				dl_s2[a]  <= dl_d[a];
				mag_s3[a] <= mag_d[a][POS_W-1:0];
				big_s3[a] <= (mag_d[a][DL_W-1:POS_W] != '0);
				sq_s4[a]  <= mag_s3[a] * mag_s3[a];
			end
			big_s4 <= big_s3[0] | big_s3[1] | big_s3[2];
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			big_s5 <= big_s4;
			hit_s6 <= !big_s5 && (sum_s5 < SUM_W'(cut_q));
		end
	end

	// current image result
	assign cur_hit  = v_s6 && hit_s6;
	assign room     = (cnt_q < CNT_W'(MAX_NEIGHBORS));
	assign cur_kind = room ? RK_NEIGHBOR : RK_DROPPED;
	assign cur_slot = room ? cnt_q[SLOT_W-1:0] : '0;

	always_comb begin
		for (int a = 0; a < NAXES; a++) cur_c[a] = sat_img(img_s6[a]);
	end

	// output and pending hold selection
	always_comb begin
		ld_out    = 1'b0;
		ld_sel    = OS_CENTER;
		ld_last   = 1'b0;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		flush_set = 1'b0;
		if (cmd.emit_center) begin
			ld_out  = 1'b1;
			ld_sel  = OS_CENTER;
			ld_last = 1'b1;
		end else if (flush_q) begin
			ld_out   = 1'b1;
			ld_sel   = OS_PEND;
			ld_last  = 1'b1;
			pend_clr = 1'b1;
		end else if (cur_hit) begin
			if (fin_s6 && !pend_v_q) begin
				ld_out  = 1'b1;
				ld_sel  = OS_CUR;
				ld_last = 1'b1;
			end else begin
				ld_out    = pend_v_q;
				ld_sel    = OS_PEND;
				pend_set  = 1'b1;
				flush_set = fin_s6;
			end
		end else if (v_s6 && fin_s6 && pend_v_q) begin
			ld_out   = 1'b1;
			ld_sel   = OS_PEND;
			ld_last  = 1'b1;
			pend_clr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ld_out;
			if (cmd.emit_center) begin
				for (int a = 0; a < NAXES; a++) center_q[a] <= wrapped[a];
				cnt_q <= '0;
			end else if (cur_hit && room) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pend_set) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (flush_set) begin
				flush_q <= 1'b1;
			end else if (pend_clr) begin
				flush_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pend_set) begin
				for (int a = 0; a < NAXES; a++) pend_c_q[a] <= cur_c[a];
				pend_kind_q <= cur_kind;
				pend_slot_q <= cur_slot;
			end
			if (ld_out) begin
				out_last_q <= ld_last;
				case (ld_sel)
					OS_PEND: begin
						for (int a = 0; a < NAXES; a++) out_c_q[a] <= pend_c_q[a];
						for (int j = 0; j < 6; j++) out_pair_q[j] <= pair_q[j];
						out_kind_q <= pend_kind_q;
						out_slot_q <= pend_slot_q;
					end
					OS_CUR: begin
						for (int a = 0; a < NAXES; a++) out_c_q[a] <= cur_c[a];
						for (int j = 0; j < 6; j++) out_pair_q[j] <= pair_q[j];
						out_kind_q <= cur_kind;
						out_slot_q <= cur_slot;
					end
					default: begin
						for (int a = 0; a < NAXES; a++) out_c_q[a] <= wrapped[a];
						for (int j = 0; j < 6; j++) out_pair_q[j] <= '0;
						out_kind_q <= RK_CENTER;
						out_slot_q <= '0;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_kind_q;
	assign out_x        = out_c_q[0];
	assign out_y        = out_c_q[1];
	assign out_z        = out_c_q[2];
	assign out_radius_a = out_pair_q[0];
	assign out_radius_b = out_pair_q[1];
	assign out_radius_c = out_pair_q[2];
	assign out_energy_a = out_pair_q[3];
	assign out_energy_b = out_pair_q[4];
	assign out_energy_c = out_pair_q[5];
	assign slot         = out_slot_q;
	assign last         = out_last_q;

endmodule

// ----- rtl/core/periodic_neighbor_list_builder.sv -----
// Periodic neighbor list builder.
// Input channel (in_valid/in_ready): kind 0 sets a new list center, kind 1 is an
// atom to test. Output channel (out_valid/out_ready) returns result items;
// "last" marks the final item caused by one input item.
// Config (cfg_en/cfg_addr/cfg_data): box lengths x, y, z and squared cutoff,
// written by the user only while the block is idle, which the block itself
// does not enforce; one write per enabled cycle.
// Center item: a bit-serial remainder per axis wraps the position into the box,
// then the emit state commits it as the list center and the result item.
// Atom item: 27 images issued one per cycle, while the receiver does not stall,
// into the single shared 6-stage distance pipeline (image add, delta, abs,
// square, sum, compare); the next item is taken only once it has drained.
// An atom with no hits gives no item. A hit waits in the pending register
// until its "last" bit is known, unless it is final with none held.
// in_ready is high only between items; a finished result may still wait in
// the output register while the next item is taken.
// A stalled receiver freezes the whole image pipeline; nothing is lost.
// Reset (arst_n low): box lengths 1.0, cutoff 0, center at origin, empty list.
module periodic_neighbor_list_builder (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_en,
	input  logic [pnl_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [pnl_pkg::CFG_DW-1:0]        cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_x,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_y,
	input  logic signed [pnl_pkg::POS_W-1:0]  pos_z,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_a,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_b,
	input  logic [pnl_pkg::WORD_W-1:0]        radius_c,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_a,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_b,
	input  logic [pnl_pkg::WORD_W-1:0]        energy_c,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        result_kind,
	output logic signed [pnl_pkg::POS_W-1:0]  out_x,
	output logic signed [pnl_pkg::POS_W-1:0]  out_y,
	output logic signed [pnl_pkg::POS_W-1:0]  out_z,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_a,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_b,
	output logic [pnl_pkg::WORD_W-1:0]        out_radius_c,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_a,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_b,
	output logic [pnl_pkg::WORD_W-1:0]        out_energy_c,
	output logic [pnl_pkg::SLOT_W-1:0]        slot,
	output logic                              last
);
	import pnl_pkg::*;

	pnl_cmd_t  cmd;
	pnl_stat_t stat;

	// sequencer: wrap steps, image order, drain
	pnl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// wrap units, image pipeline, list count and output register
	pnl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_en       (cfg_en),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.radius_a     (radius_a),
		.radius_b     (radius_b),
		.radius_c     (radius_c),
		.energy_a     (energy_a),
		.energy_b     (energy_b),
		.energy_c     (energy_c),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.out_radius_a (out_radius_a),
		.out_radius_b (out_radius_b),
		.out_radius_c (out_radius_c),
		.out_energy_a (out_energy_a),
		.out_energy_b (out_energy_b),
		.out_energy_c (out_energy_c),
		.slot         (slot),
		.last         (last)
	);

endmodule

// ----- sim/periodic_neighbor_list_builder_tb.sv -----
`timescale 1ns / 100ps

module periodic_neighbor_list_builder_tb;
	import pnl_pkg::*;

	// cycles of quiet allowed before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	// an atom with no hits can keep the block busy with no item out
	localparam int SETTLE_CYCLES  = 60;
	localparam int ITEMS_PER_SET  = 39;
	localparam int NUM_SETS       = 8;
	localparam int IDLE_PCT       = 19;

	typedef logic [NAXES-1:0][POS_W-1:0] coords_t;
	typedef logic [5:0][WORD_W-1:0]      pair_words_t;

	// one input item: kind, position, six pass-through pair words
	typedef struct packed {
		in_kind_t    kind;
		coords_t     pos;
		pair_words_t words;
	} in_item_t;

	// one result item as the block should present it
	typedef struct packed {
		rkind_t            kind;
		coords_t           pos;
		pair_words_t       words;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} nbr_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_en   = 1'b0;
	logic [CFG_AW-1:0]       cfg_addr = '0;
	logic [CFG_DW-1:0]       cfg_data = '0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    kind     = 1'b0;
	logic signed [POS_W-1:0] pos_x    = '0;
	logic signed [POS_W-1:0] pos_y    = '0;
	logic signed [POS_W-1:0] pos_z    = '0;
	logic [WORD_W-1:0]       radius_a = '0;
	logic [WORD_W-1:0]       radius_b = '0;
	logic [WORD_W-1:0]       radius_c = '0;
	logic [WORD_W-1:0]       energy_a = '0;
	logic [WORD_W-1:0]       energy_b = '0;
	logic [WORD_W-1:0]       energy_c = '0;

	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              result_kind;
	logic signed [POS_W-1:0] out_x;
	logic signed [POS_W-1:0] out_y;
	logic signed [POS_W-1:0] out_z;
	logic [WORD_W-1:0]       out_radius_a;
	logic [WORD_W-1:0]       out_radius_b;
	logic [WORD_W-1:0]       out_radius_c;
	logic [WORD_W-1:0]       out_energy_a;
	logic [WORD_W-1:0]       out_energy_b;
	logic [WORD_W-1:0]       out_energy_c;
	logic [SLOT_W-1:0]       slot;
	logic                    last;

	// shadow copy of the block: registers, list center, neighbor count
	longint          box_len [NAXES];
	longint unsigned cut_sq;
	longint          list_center [NAXES];
	int              list_count;

	nbr_result_t pending_results [$];
	nbr_result_t want_res;
	int          mismatches   = 0;
	int          stall_cycles = 0;
	// when set, neither side idles
	logic        calm         = 1'b0;

	periodic_neighbor_list_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_en       (cfg_en),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.radius_a     (radius_a),
		.radius_b     (radius_b),
		.radius_c     (radius_c),
		.energy_a     (energy_a),
		.energy_b     (energy_b),
		.energy_c     (energy_c),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.out_radius_a (out_radius_a),
		.out_radius_b (out_radius_b),
		.out_radius_c (out_radius_c),
		.out_energy_a (out_energy_a),
		.out_energy_b (out_energy_b),
		.out_energy_c (out_energy_c),
		.slot         (slot),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor arithmetic, all in 64-bit integers
	// ---------------------------------------------------------------

	// remainder into [0, box); a zero box leaves the axis alone
	function automatic longint wrap_coord(longint p, longint b);
		longint r;
		if (b == 0)
			return p;
		r = p % b;
		if (r < 0)
			r += b;
		return r;
	endfunction

	// square of |d|, pinned to all ones once |d| no longer fits 32 bits
	function automatic longint unsigned dist_sq(longint d);
		longint unsigned m;
		m = (d < 0) ? -d : d;
		if (m > 64'hFFFF_FFFF)
			return '1;
		return m * m;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned x, longint unsigned y);
		return (x > ~y) ? '1 : x + y;
	endfunction

	// image coordinates leave the block saturated to signed 32 bits
	function automatic logic [POS_W-1:0] clamp32(longint v);
		if (v > longint'(32'h7FFF_FFFF))
			return 32'h7FFF_FFFF;
		if (v < -longint'(32'h8000_0000))
			return 32'h8000_0000;
		return v[POS_W-1:0];
	endfunction

	// work out every result caused by one accepted item and queue them
	task automatic predict_item(in_item_t it);
		nbr_result_t     r;
		nbr_result_t     hits [$];
		longint          p [NAXES];
		longint          img [NAXES];
		longint unsigned dd;
		for (int a = 0; a < NAXES; a++)
			p[a] = longint'($signed(it.pos[a]));
		if (it.kind == KIND_CENTER) begin
			r = '0;
			r.kind = RK_CENTER;
			for (int a = 0; a < NAXES; a++) begin
				list_center[a] = wrap_coord(p[a], box_len[a]);
				r.pos[a] = clamp32(list_center[a]);
			end
			r.last = 1'b1;
			list_count = 0;
			pending_results.push_back(r);
			return;
		end
		// x outer, z inner, shift -1..+1
		for (int sx = -1; sx <= 1; sx++)
			for (int sy = -1; sy <= 1; sy++)
				for (int sz = -1; sz <= 1; sz++) begin
					img[0] = sx * box_len[0] + p[0];
					img[1] = sy * box_len[1] + p[1];
					img[2] = sz * box_len[2] + p[2];
					dd = sat_sum(sat_sum(dist_sq(img[0] - list_center[0]),
						dist_sq(img[1] - list_center[1])),
						dist_sq(img[2] - list_center[2]));
					if (dd < cut_sq) begin
						r = '0;
						for (int a = 0; a < NAXES; a++)
							r.pos[a] = clamp32(img[a]);
						r.words = it.words;
						if (list_count < MAX_NEIGHBORS) begin
							r.kind = RK_NEIGHBOR;
							r.slot = SLOT_W'(list_count);
							list_count++;
						end else begin
							// list full: flagged, slot zero, count held
							r.kind = RK_DROPPED;
						end
						hits.push_back(r);
					end
				end
		if (hits.size() > 0)
			hits[hits.size() - 1].last = 1'b1;
		foreach (hits[i])
			pending_results.push_back(hits[i]);
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic in_item_t make_item(in_kind_t k, logic [POS_W-1:0] x,
		logic [POS_W-1:0] y, logic [POS_W-1:0] z, pair_words_t w);
		in_item_t it;
		it.kind   = k;
		it.pos[0] = x;
		it.pos[1] = y;
		it.pos[2] = z;
		it.words  = w;
		return it;
	endfunction

	function automatic pair_words_t rand_words();
		pair_words_t w;
		for (int i = 0; i < 6; i++)
			w[i] = $urandom;
		return w;
	endfunction

	function automatic longint rand_box();
		longint b;
		b = longint'($urandom_range(65536, 1 << 20)) << $urandom_range(0, 11);
		if (b > 64'sh7FFF_FFFF)
			b = 64'sh7FFF_FFFF;
		return b;
	endfunction

	// coordinate within about one box length of the current center
	function automatic logic [POS_W-1:0] near_coord(int a);
		longint span;
		longint off;
		span = (box_len[a] == 0) ? 64'sd262144 : box_len[a];
		off = longint'({$urandom, $urandom} % $unsigned(2 * span + 1)) - span;
		return clamp32(list_center[a] + off);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(in_item_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= it.kind;
		pos_x    <= it.pos[0];
		pos_y    <= it.pos[1];
		pos_z    <= it.pos[2];
		radius_a <= it.words[0];
		radius_b <= it.words[1];
		radius_c <= it.words[2];
		energy_a <= it.words[3];
		energy_b <= it.words[4];
		energy_c <= it.words[5];
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(it);
		@(negedge clk);
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_addr_t idx, logic [CFG_DW-1:0] data);
		cfg_en   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		case (idx)
			CFG_BOX_X:  box_len[0] = longint'(data[BOX_W-1:0]);
			CFG_BOX_Y:  box_len[1] = longint'(data[BOX_W-1:0]);
			CFG_BOX_Z:  box_len[2] = longint'(data[BOX_W-1:0]);
			CFG_CUTOFF: cut_sq     = 64'(data[CUT_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// waits for the block to go idle, then writes all four registers;
	// junk puts random bits above the 31-bit box fields
	task automatic program_regs(longint bx, longint by, longint bz,
		longint unsigned cut, bit junk);
		hold_input();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_BOX_X, {(junk ? 32'($urandom) : 32'h0), bx[BOX_W-1:0]});
		write_reg(CFG_BOX_Y, {(junk ? 32'($urandom) : 32'h0), by[BOX_W-1:0]});
		write_reg(CFG_BOX_Z, {(junk ? 32'($urandom) : 32'h0), bz[BOX_W-1:0]});
		write_reg(CFG_CUTOFF, cut[CUT_W-1:0]);
		cfg_en <= 1'b0;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset config (cutoff 0) finds nothing; then atoms before any center
	// are tested against the origin
	task automatic test_reset_state();
		send_item(make_item(KIND_ATOM, 32'h0, 32'h0, 32'h0, rand_words()));
		program_regs(65536, 65536, 65536, 64'h4_0000_0000, 1'b0);
		send_item(make_item(KIND_ATOM, 32'h0000_4000, 32'h0000_8000, 32'hFFFF_8000, '1));
		send_item(make_item(KIND_ATOM, 32'hFFFF_C000, 32'h0, 32'h0001_0000, '0));
	endtask

	// centers at the coordinate extremes, negatives and exact box multiples
	task automatic test_center_wrap();
		program_regs(655360, 229376, 64'sh7FFF_FFFF, 64'h2_4000_0000, 1'b0);
		send_item(make_item(KIND_CENTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1));
		send_item(make_item(KIND_CENTER, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1));
		send_item(make_item(KIND_ATOM, near_coord(0), near_coord(1), near_coord(2), '1));
		send_item(make_item(KIND_CENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
		send_item(make_item(KIND_CENTER, 32'h0, 32'h0, 32'h0, rand_words()));
		send_item(make_item(KIND_CENTER, 32'h001E_0000, 32'hFFFC_8000, 32'h0, '0));
		send_item(make_item(KIND_ATOM, 32'h001E_8000, 32'hFFFC_0000, 32'h0000_4000, '0));
	endtask

	// widest box and cutoff: images run past the 32-bit range and saturate
	task automatic test_image_saturation();
		program_regs(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_item(make_item(KIND_CENTER, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFE, '0));
		send_item(make_item(KIND_ATOM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			rand_words()));
		send_item(make_item(KIND_ATOM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			rand_words()));
		send_item(make_item(KIND_CENTER, 32'h8000_0000, 32'h0, 32'h8000_0001, '0));
		send_item(make_item(KIND_ATOM, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, rand_words()));
	endtask

	// zero box on x and z: center stays unwrapped, images coincide there
	task automatic test_zero_box();
		program_regs(0, 262144, 0, 64'h4_0000_0000, 1'b0);
		send_item(make_item(KIND_CENTER, 32'hFFFC_C000, 32'h0005_8000, 32'hFFFF_0000, '0));
		send_item(make_item(KIND_ATOM, 32'hFFFD_0000, 32'h0001_0000, 32'hFFFE_8000,
			rand_words()));
		send_item(make_item(KIND_ATOM, 32'h0064_0000, 32'h0, 32'h0, rand_words()));
	endtask

	// every image hits: the list fills past capacity, then a new center
	// empties it; run with both sides always ready
	task automatic test_list_overflow();
		program_regs(65536, 65536, 65536, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		calm <= 1'b1;
		send_item(make_item(KIND_CENTER, 32'h0, 32'h0, 32'h0, '0));
		for (int i = 0; i < 40; i++)
			send_item(make_item(KIND_ATOM,
				32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000,
				32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000,
				32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000,
				rand_words()));
		calm <= 1'b0;
		// sender waits here until the whole list has come out
		hold_input();
		drain();
		send_item(make_item(KIND_CENTER, 32'h0000_8000, 32'h0, 32'h0, '0));
		send_item(make_item(KIND_ATOM, 32'h0, 32'h0, 32'h0, rand_words()));
	endtask

	// several settings, extremes among them; mostly atoms near the center,
	// the rest new centers and atoms anywhere
	task automatic test_random_settings();
		longint          bx, by, bz, rmax, r;
		longint unsigned cut;
		int              pick;
		for (int s = 0; s < NUM_SETS; s++) begin
			bx = rand_box();
			by = rand_box();
			bz = rand_box();
			case (s)
				0: begin
					bx = 65536;
					by = 65536;
					bz = 65536;
				end
				1: begin
					bx = 64'sh7FFF_FFFF;
					by = 64'sh7FFF_FFFF;
					bz = 64'sh7FFF_FFFF;
				end
				3: by = 65536;
				default: ;
			endcase
			rmax = bx;
			if (by > rmax)
				rmax = by;
			if (bz > rmax)
				rmax = bz;
			rmax = rmax + rmax / 5;
			r = longint'({$urandom, $urandom} % $unsigned(rmax + 1));
			cut = r * r;
			case (s)
				1: cut = 64'h7FFF_FFFF_FFFF_FFFF;
				2: cut = 0;
				3: cut = {$urandom, $urandom} >> 1;
				default: ;
			endcase
			program_regs(bx, by, bz, cut, 1'b1);
			send_item(make_item(KIND_CENTER, $urandom, $urandom, $urandom, rand_words()));
			for (int i = 1; i < ITEMS_PER_SET; i++) begin
				if (i == 23) begin
					hold_input();
					drain();
				end
				pick = $urandom_range(99);
				if (pick < 8)
					send_item(make_item(KIND_CENTER, $urandom, $urandom, $urandom,
						rand_words()));
				else if (pick < 18)
					send_item(make_item(KIND_ATOM, $urandom, $urandom, $urandom,
						rand_words()));
				else
					send_item(make_item(KIND_ATOM, near_coord(0), near_coord(1),
						near_coord(2), rand_words()));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				mismatches++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("result_kind", 64'(want_res.kind), 64'(result_kind));
				check_field("out_x", 64'(want_res.pos[0]), 64'($unsigned(out_x)));
				check_field("out_y", 64'(want_res.pos[1]), 64'($unsigned(out_y)));
				check_field("out_z", 64'(want_res.pos[2]), 64'($unsigned(out_z)));
				check_field("out_radius_a", 64'(want_res.words[0]), 64'(out_radius_a));
				check_field("out_radius_b", 64'(want_res.words[1]), 64'(out_radius_b));
				check_field("out_radius_c", 64'(want_res.words[2]), 64'(out_radius_c));
				check_field("out_energy_a", 64'(want_res.words[3]), 64'(out_energy_a));
				check_field("out_energy_b", 64'(want_res.words[4]), 64'(out_energy_b));
				check_field("out_energy_c", 64'(want_res.words[5]), 64'(out_energy_c));
				check_field("slot", 64'(want_res.slot), 64'(slot));
				check_field("last", 64'(want_res.last), 64'(last));
			end
		end
	end

	// hang detector: any accepted item on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("** periodic_neighbor_list_builder: FAILED **");
			$finish;
		end
	end

	initial begin
		box_len[0]     = 65536;
		box_len[1]     = 65536;
		box_len[2]     = 65536;
		cut_sq         = 0;
		list_center[0] = 0;
		list_center[1] = 0;
		list_center[2] = 0;
		list_count     = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_center_wrap();
		test_image_saturation();
		test_zero_box();
		test_list_overflow();
		test_random_settings();

		hold_input();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** periodic_neighbor_list_builder: PASSED **");
		else
			$display("** periodic_neighbor_list_builder: FAILED **");
		$finish;
	end

endmodule
